// ----- sv/distance_vector_route_update_unit_defines.svh -----
// Assertion macros for the distance-vector route update unit.
// Included by the modules that carry concurrent checks; uses aclk and aresetn.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication
`define DVRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dvru_pkg.sv -----
// Shared types and constants of the distance-vector route update unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvru_pkg;

    localparam int APB_AW = 5;

    localparam logic [31:0] COST_INF = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_OWN_A     = 3'd0;
    localparam logic [2:0] REG_OWN_B     = 3'd1;
    localparam logic [2:0] REG_OWN_C     = 3'd2;
    localparam logic [2:0] REG_OWN_D     = 3'd3;
    localparam logic [2:0] REG_OWN_COUNT = 3'd4;

    localparam logic [3:0] ST_OWN      = 4'd0;
    localparam logic [3:0] ST_INSERTED = 4'd1;
    localparam logic [3:0] ST_REMOVED  = 4'd2;
    localparam logic [3:0] ST_REFRESH  = 4'd3;
    localparam logic [3:0] ST_REPLACED = 4'd4;
    localparam logic [3:0] ST_BETTER   = 4'd5;
    localparam logic [3:0] ST_NOCHANGE = 4'd6;
    localparam logic [3:0] ST_STALE    = 4'd7;
    localparam logic [3:0] ST_DROPPED  = 4'd8;
    localparam logic [3:0] ST_FULL     = 4'd9;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] seq;
        logic [31:0] cost;
        logic [15:0] face;
    } entry_t;

    typedef struct packed {
        logic clr;
        logic cnt_rst;
        logic capture;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic own_in;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/dvru_ctrl.sv -----
// Controller FSM: table clear after reset, item capture, table scan, commit.
// Depends on dvru_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "distance_vector_route_update_unit_defines.svh"

module dvru_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dvru_pkg::sts_t sts,
    output dvru_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    cmd.cnt_rst = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cmd.cnt_rst = 1'b1;
                    state_next  = sts.own_in ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_end) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `DVRU_ASSERT_NOW(a_ctrl_clr_excl, cmd.clr, !(cmd.scan || cmd.capture || cmd.commit), "clear overlaps work")
    `DVRU_ASSERT_NEXT(a_ctrl_capture_busy, cmd.capture, !s_ready, "ready held during item work")
    `DVRU_ASSERT_NOW(a_ctrl_commit_free, cmd.commit, sts.out_free, "commit into busy output")

endmodule

`default_nettype wire

// ----- sv/dvru_datapath.sv -----
// Datapath: route table memory, scan match logic, update decision, result register.
// Depends on dvru_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "distance_vector_route_update_unit_defines.svh"

module dvru_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dvru_pkg::cmd_t cmd,
    output dvru_pkg::sts_t     sts,
    input  wire logic [31:0]   own_a,
    input  wire logic [31:0]   own_b,
    input  wire logic [31:0]   own_c,
    input  wire logic [31:0]   own_d,
    input  wire logic [2:0]    own_count,
    input  wire logic [31:0]   s_prefix_key,
    input  wire logic [63:0]   s_received_seq,
    input  wire logic [31:0]   s_received_cost,
    input  wire logic [15:0]   s_neighbor_face,
    input  wire logic          s_last_of_update,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [3:0]         m_status,
    output logic               m_announce,
    output logic [31:0]        m_stored_cost,
    output logic [15:0]        m_stored_face,
    output logic               m_update_changed
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    dvru_pkg::entry_t mem [TABLE_ENTRIES];
    dvru_pkg::entry_t rdata_reg;

    logic [CW-1:0] cnt_reg;
    logic          eval_reg;
    logic [AW-1:0] eval_idx_reg;

    logic [31:0] key_reg;
    logic [63:0] seq_reg;
    logic [31:0] cost_reg;
    logic [15:0] face_reg;
    logic        last_reg;
    logic        own_reg;

    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [63:0]   hit_seq_reg;
    logic [31:0]   hit_cost_reg;
    logic [15:0]   hit_face_reg;
    logic          free_reg;
    logic [AW-1:0] free_idx_reg;
    logic          pending_reg;

    logic        scan_end;
    logic [2:0]  own_n;
    logic        own_in;

    always_comb begin
        own_n  = (own_count > 3'd4) ? 3'd4 : own_count;
        own_in = ((own_n > 3'd0) && (s_prefix_key == own_a))
              || ((own_n > 3'd1) && (s_prefix_key == own_b))
              || ((own_n > 3'd2) && (s_prefix_key == own_c))
              || ((own_n > 3'd3) && (s_prefix_key == own_d));
    end

    assign scan_end     = (cnt_reg == CW'(TABLE_ENTRIES));
    assign sts.scan_end = scan_end;
    assign sts.clr_last = (cnt_reg == CW'(TABLE_ENTRIES - 1));
    assign sts.own_in   = own_in;
    assign sts.out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            eval_reg <= 1'b0;
        end else begin
            eval_reg <= cmd.scan && !scan_end;
            if (cmd.cnt_rst) begin
                cnt_reg <= '0;
            end else if (cmd.clr || (cmd.scan && !scan_end)) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        eval_idx_reg <= cnt_reg[AW-1:0];
        if (cmd.scan && !scan_end) begin
            rdata_reg <= mem[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg  <= s_prefix_key;
            seq_reg  <= s_received_seq;
            cost_reg <= s_received_cost;
            face_reg <= s_neighbor_face;
            last_reg <= s_last_of_update;
            own_reg  <= own_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (cmd.capture) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (eval_reg) begin
            if (rdata_reg.valid) begin
                if (!hit_reg && (rdata_reg.key == key_reg)) begin
                    hit_reg <= 1'b1;
                end
            end else if (!free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_reg) begin
            if (rdata_reg.valid && !hit_reg && (rdata_reg.key == key_reg)) begin
                hit_idx_reg  <= eval_idx_reg;
                hit_seq_reg  <= rdata_reg.seq;
                hit_cost_reg <= rdata_reg.cost;
                hit_face_reg <= rdata_reg.face;
            end
            if (!rdata_reg.valid && !free_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
        end
    end

    // update decision
    logic [31:0]      nc;
    logic [3:0]       st;
    logic             ann;
    logic [31:0]      s_cost;
    logic [15:0]      s_face;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    dvru_pkg::entry_t wr_entry;
    logic             replace;

    always_comb begin
        nc       = cost_reg + 32'd1;
        st       = dvru_pkg::ST_DROPPED;
        ann      = 1'b0;
        s_cost   = dvru_pkg::COST_INF;
        s_face   = '0;
        wr_en    = 1'b0;
        wr_idx   = hit_idx_reg;
        replace  = 1'b0;
        wr_entry = '{valid: 1'b1, key: key_reg, seq: hit_seq_reg,
                     cost: hit_cost_reg, face: hit_face_reg};
        if (own_reg) begin
            st     = dvru_pkg::ST_OWN;
            s_cost = '0;
        end else if (!hit_reg && (seq_reg != 64'd0) && (cost_reg != dvru_pkg::COST_INF)) begin
            if (!free_reg) begin
                st = dvru_pkg::ST_FULL;
            end else begin
                st       = dvru_pkg::ST_INSERTED;
                ann      = 1'b1;
                s_cost   = nc;
                s_face   = face_reg;
                wr_en    = 1'b1;
                wr_idx   = free_idx_reg;
                wr_entry = '{valid: 1'b1, key: key_reg, seq: seq_reg,
                             cost: nc, face: face_reg};
            end
        end else if (cost_reg == dvru_pkg::COST_INF) begin
            st             = dvru_pkg::ST_REMOVED;
            ann            = 1'b1;
            wr_en          = hit_reg;
            wr_entry.valid = 1'b0;
        end else if (!hit_reg) begin
            st = dvru_pkg::ST_DROPPED;
        end else begin
            s_cost = hit_cost_reg;
            s_face = hit_face_reg;
            if (seq_reg > hit_seq_reg) begin
                wr_en        = 1'b1;
                wr_entry.seq = seq_reg;
                if (hit_cost_reg == nc) begin
                    st = dvru_pkg::ST_REFRESH;
                end else begin
                    st            = dvru_pkg::ST_REPLACED;
                    replace       = 1'b1;
                    wr_entry.cost = nc;
                    wr_entry.face = face_reg;
                    s_cost        = nc;
                    s_face        = face_reg;
                end
            end else if ((seq_reg == hit_seq_reg) && (nc < hit_cost_reg)) begin
                st            = dvru_pkg::ST_BETTER;
                replace       = 1'b1;
                wr_en         = 1'b1;
                wr_entry.cost = nc;
                wr_entry.face = face_reg;
                s_cost        = nc;
                s_face        = face_reg;
            end else if (seq_reg == hit_seq_reg) begin
                st = dvru_pkg::ST_NOCHANGE;
            end else begin
                st = dvru_pkg::ST_STALE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[cnt_reg[AW-1:0]] <= '0;
        end else if (cmd.commit && wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            m_valid     <= 1'b0;
        end else begin
            if (cmd.commit) begin
                pending_reg <= last_reg ? 1'b0 : (pending_reg || replace);
                m_valid     <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status         <= st;
            m_announce       <= ann;
            m_stored_cost    <= s_cost;
            m_stored_face    <= s_face;
            m_update_changed <= last_reg && (pending_reg || replace);
        end
    end

    `DVRU_ASSERT_NOW(a_dp_no_overwrite, m_valid && !m_ready, !cmd.commit, "result overwritten")
    `DVRU_ASSERT_NEXT(a_dp_commit_valid, cmd.commit, m_valid, "commit without result")
    `DVRU_ASSERT_NOW(a_dp_scan_needs_item, eval_reg, !cmd.capture && !cmd.clr, "scan overlaps capture")

endmodule

`default_nettype wire

// ----- sv/distance_vector_route_update_unit.sv -----
// Flow: an input transfer is captured, the one-entry-per-cycle table scan seeks a matching
// entry and a free slot, and the update decision is committed to the result register; own
// prefixes skip it. Input waits for the commit, which waits while m_ready holds a result.
// Reset: synchronous active-low aresetn; afterwards a clearing pass writes every table entry
// invalid, and no input transfer is taken until it ends.
// Configuration registers reset to zero and are writable during the pass.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_update_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dvru_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_prefix_key,
    input  wire logic [63:0]                   s_received_seq,
    input  wire logic [31:0]                   s_received_cost,
    input  wire logic [15:0]                   s_neighbor_face,
    input  wire logic                          s_last_of_update,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [3:0]                         m_status,
    output logic                               m_announce,
    output logic [31:0]                        m_stored_cost,
    output logic [15:0]                        m_stored_face,
    output logic                               m_update_changed
);

    logic [31:0] own_a_reg;
    logic [31:0] own_b_reg;
    logic [31:0] own_c_reg;
    logic [31:0] own_d_reg;
    logic [2:0]  own_count_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    dvru_pkg::cmd_t cmd;
    dvru_pkg::sts_t sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_a_reg     <= '0;
            own_b_reg     <= '0;
            own_c_reg     <= '0;
            own_d_reg     <= '0;
            own_count_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                dvru_pkg::REG_OWN_A:     own_a_reg     <= pwdata;
                dvru_pkg::REG_OWN_B:     own_b_reg     <= pwdata;
                dvru_pkg::REG_OWN_C:     own_c_reg     <= pwdata;
                dvru_pkg::REG_OWN_D:     own_d_reg     <= pwdata;
                dvru_pkg::REG_OWN_COUNT: own_count_reg <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dvru_pkg::REG_OWN_A:     prdata = own_a_reg;
            dvru_pkg::REG_OWN_B:     prdata = own_b_reg;
            dvru_pkg::REG_OWN_C:     prdata = own_c_reg;
            dvru_pkg::REG_OWN_D:     prdata = own_d_reg;
            dvru_pkg::REG_OWN_COUNT: prdata = {29'd0, own_count_reg};
            default:                 prdata = '0;
        endcase
    end

    dvru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dvru_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .own_a            (own_a_reg),
        .own_b            (own_b_reg),
        .own_c            (own_c_reg),
        .own_d            (own_d_reg),
        .own_count        (own_count_reg),
        .s_prefix_key     (s_prefix_key),
        .s_received_seq   (s_received_seq),
        .s_received_cost  (s_received_cost),
        .s_neighbor_face  (s_neighbor_face),
        .s_last_of_update (s_last_of_update),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_announce       (m_announce),
        .m_stored_cost    (m_stored_cost),
        .m_stored_face    (m_stored_face),
        .m_update_changed (m_update_changed)
    );

endmodule

`default_nettype wire
